// ===== hw/rtl/rrpq_pkg.sv =====
// rrpq_pkg: shared types and codes for the round-robin process queue.
// Used by the front end, the scheduler back end, the result queue and the checker.
`timescale 1ns / 1ps

package rrpq_pkg;

  // Operation carried by an input beat
  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_ADDED     = 2'd0,
    STATUS_REQUEUED  = 2'd1,
    STATUS_FINISHED  = 2'd2,
    STATUS_IDLE_FULL = 2'd3
  } status_e;

  localparam int unsigned IdW      = 8;
  localparam int unsigned FieldTW  = 16;
  localparam int unsigned OccW     = 5;

  // Classified command handed from the front end to the back end
  typedef struct packed {
    op_e                op;
    logic [IdW-1:0]     proc_id;
    logic [FieldTW-1:0] required_time;
  } cmd_t;

  // One result beat
  typedef struct packed {
    status_e            status;
    logic               queue_full;
    logic [IdW-1:0]     ran_id;
    logic [FieldTW-1:0] ran_time;
    logic [FieldTW-1:0] needed_time;
    logic [OccW-1:0]    occupancy;
  } res_t;

endpackage

// ===== hw/rtl/rrpq_front.sv =====
// rrpq_front: accepts input beats, classifies them and holds them in a
// two-entry command queue for the back end. Depends on rrpq_pkg.
`timescale 1ns / 1ps

module rrpq_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic                    mode_i,
  input  logic [7:0]              proc_id_i,
  input  logic [15:0]             required_time_i,
  output logic                    cmd_valid_o,
  output rrpq_pkg::cmd_t          cmd_o,
  input  logic                    cmd_pop_i
);
  import rrpq_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  cmd_t            fifo_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            wr_en;
  cmd_t            cmd_new;

  assign full        = (cnt_q == CntW'(Depth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign wr_en       = push && !full;

  always_comb begin
    cmd_new.op            = op_e'(mode_i);
    cmd_new.proc_id       = proc_id_i;
    cmd_new.required_time = required_time_i;
  end

  always_comb begin
    wr_ptr_d = wr_en ? ((wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? ((rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en && !cmd_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en && cmd_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ===== hw/rtl/rrpq_back.sv =====
// rrpq_back: scheduler engine. Owns the process store and the head, tail
// and count registers; turns each command into one result. Depends on rrpq_pkg.
`timescale 1ns / 1ps

module rrpq_back #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TIME_BITS   = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  rrpq_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic           res_full_i,
  output logic           res_push_o,
  output rrpq_pkg::res_t res_o
);
  import rrpq_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [IdW-1:0]       id;
    logic [TIME_BITS-1:0] need;
    logic [TIME_BITS-1:0] done;
  } entry_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e          state_q, state_d;
  logic [PtrW-1:0] head_q, head_d;
  logic [PtrW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;

  entry_t          store_q [QUEUE_DEPTH];
  entry_t          rd_q;
  logic            rd_en;
  logic            wr_en;
  entry_t          wr_data;

  logic [TIME_BITS-1:0] done_inc;
  logic                 finish;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // saturating one-tick increment of the head entry read last cycle
  assign done_inc = (rd_q.done == '1) ? rd_q.done : rd_q.done + 1'b1;
  assign finish   = (done_inc >= rd_q.need);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    wr_data    = rd_q;
    res_o      = '0;

    unique case (state_q)
      ST_IDLE: begin
        // only one item in flight, so room seen here still holds in ST_RUN
        if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            OP_ADD: begin
              res_push_o = 1'b1;
              if (count_q == CntW'(QUEUE_DEPTH)) begin
                res_o.status     = STATUS_IDLE_FULL;
                res_o.queue_full = 1'b1;
                res_o.occupancy  = OccW'(count_q);
              end else begin
                wr_en           = 1'b1;
                wr_data.id      = cmd_i.proc_id;
                wr_data.need    = TIME_BITS'(cmd_i.required_time);
                wr_data.done    = '0;
                tail_d          = next_ptr(tail_q);
                count_d         = count_q + 1'b1;
                res_o.status    = STATUS_ADDED;
                res_o.occupancy = OccW'(count_d);
              end
            end
            OP_TICK: begin
              if (count_q == '0) begin
                res_push_o      = 1'b1;
                res_o.status    = STATUS_IDLE_FULL;
                res_o.occupancy = OccW'(count_q);
              end else begin
                rd_en   = 1'b1;
                state_d = ST_RUN;
              end
            end
          endcase
        end
      end
      ST_RUN: begin
        res_push_o        = 1'b1;
        head_d            = next_ptr(head_q);
        res_o.ran_id      = rd_q.id;
        res_o.ran_time    = FieldTW'(done_inc);
        res_o.needed_time = FieldTW'(rd_q.need);
        if (finish) begin
          count_d      = count_q - 1'b1;
          res_o.status = STATUS_FINISHED;
        end else begin
          // pop and push back: slot read at head is free to be the tail
          wr_en        = 1'b1;
          wr_data.done = done_inc;
          tail_d       = next_ptr(tail_q);
          res_o.status = STATUS_REQUEUED;
        end
        res_o.occupancy = OccW'(count_d);
        state_d         = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[tail_q] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= store_q[head_q];
    end
  end

endmodule

// ===== hw/rtl/rrpq_out_queue.sv =====
// rrpq_out_queue: two-entry result queue that drives the result ports.
// Depends on rrpq_pkg.
`timescale 1ns / 1ps

module rrpq_out_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           res_push_i,
  input  rrpq_pkg::res_t res_i,
  output logic           res_full_o,
  output logic           empty,
  input  logic           pop,
  output rrpq_pkg::res_t res_o
);
  import rrpq_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  res_t            fifo_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            rd_en;

  assign res_full_o = (cnt_q == CntW'(Depth));
  assign empty      = (cnt_q == '0);
  assign res_o      = fifo_q[rd_ptr_q];
  assign rd_en      = pop && !empty;

  always_comb begin
    wr_ptr_d = res_push_i ? ((wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1)
                          : wr_ptr_q;
    rd_ptr_d = rd_en ? ((rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (res_push_i && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!res_push_i && rd_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push_i) begin
      fifo_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

// ===== hw/rtl/round_robin_process_queue.sv =====
// Round-robin process queue, one-tick time slice: an add beat appends a process,
// if there is room, to a circular store of QUEUE_DEPTH entries, a tick beat runs
// the head process, if any, once and retires it or puts it back at the tail;
// every beat gives one result. Beats pass through a two-entry command queue, the
// scheduler engine and a two-entry result queue, so each side can stall on its
// own. The engine handles an add or a tick on an empty queue in its idle state; a
// tick that runs a process also passes its run state, set by the registered read
// port of the process store, and no new beat is taken meanwhile. With nothing
// ahead of it, a beat waits in the command queue and its result in the result queue.
// Depends on rrpq_pkg, rrpq_front, rrpq_back and rrpq_out_queue.
`timescale 1ns / 1ps

module round_robin_process_queue #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TIME_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        mode_i,
  input  logic [7:0]  proc_id_i,
  input  logic [15:0] required_time_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status_o,
  output logic        queue_full_o,
  output logic [7:0]  ran_id_o,
  output logic [15:0] ran_time_o,
  output logic [15:0] needed_time_o,
  output logic [4:0]  occupancy_o
);
  import rrpq_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;
  res_t res_new;
  logic res_push;
  logic res_full;
  res_t res_head;

  rrpq_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .mode_i         (mode_i),
    .proc_id_i      (proc_id_i),
    .required_time_i(required_time_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  rrpq_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TIME_BITS  (TIME_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_new)
  );

  rrpq_out_queue u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .res_push_i(res_push),
    .res_i     (res_new),
    .res_full_o(res_full),
    .empty     (empty),
    .pop       (pop),
    .res_o     (res_head)
  );

  assign status_o      = res_head.status;
  assign queue_full_o  = res_head.queue_full;
  assign ran_id_o      = res_head.ran_id;
  assign ran_time_o    = res_head.ran_time;
  assign needed_time_o = res_head.needed_time;
  assign occupancy_o   = res_head.occupancy;

endmodule

// ===== hw/rtl/rrpq_checker.sv =====
// rrpq_checker: port-level assertions for round_robin_process_queue, with the
// bind that attaches it. Depends on rrpq_pkg.
`timescale 1ns / 1ps

module rrpq_checker #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  status_o,
  input logic        queue_full_o,
  input logic [7:0]  ran_id_o,
  input logic [15:0] ran_time_o,
  input logic [15:0] needed_time_o,
  input logic [4:0]  occupancy_o
);
  import rrpq_pkg::*;

  logic       seen_q;
  logic [4:0] last_occ_q;
  logic [4:0] exp_occ;
  logic       out_beat;

  assign out_beat = pop && !empty;

  // occupancy after a beat follows from the one before it
  always_comb begin
    case (status_o)
      STATUS_ADDED:    exp_occ = last_occ_q + 5'd1;
      STATUS_FINISHED: exp_occ = last_occ_q - 5'd1;
      default:         exp_occ = last_occ_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      last_occ_q <= '0;
    end else if (out_beat) begin
      seen_q     <= 1'b1;
      last_occ_q <= occupancy_o;
    end
  end

  a_hold_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(status_o) && $stable(ran_id_o) &&
                       $stable(ran_time_o) && $stable(occupancy_o))
    else $error("result beat changed while stalled");

  a_no_run_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (status_o == STATUS_ADDED || status_o == STATUS_IDLE_FULL) |->
      ran_id_o == '0 && ran_time_o == '0 && needed_time_o == '0)
    else $error("run fields set on a beat that ran nothing");

  a_idle_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && status_o == STATUS_IDLE_FULL |->
      (queue_full_o && occupancy_o == 5'(QUEUE_DEPTH)) ||
      (!queue_full_o && occupancy_o == '0))
    else $error("idle or full beat with wrong occupancy");

  a_occ_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && seen_q |-> occupancy_o == exp_occ)
    else $error("occupancy does not follow the previous beat");

endmodule

bind round_robin_process_queue rrpq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (.*);
